FILE: hw/rtl/wsjp_pkg.sv
// Package for the weighted score job picker.
// Holds the queued job record, configuration bundle and shared constants.
// No dependencies.
package wsjp_pkg;

	localparam int DIV_W  = 47;
	localparam int DIV_CW = 6;

	localparam logic [DIV_CW-1:0] NB_KEY  = 6'd25;
	localparam logic [DIV_CW-1:0] NB_DL   = 6'd25;
	localparam logic [DIV_CW-1:0] NB_FAIR = 6'd19;
	localparam logic [DIV_CW-1:0] NB_T    = 6'd47;
	localparam logic [DIV_CW-1:0] NB_BW   = 6'd17;

	localparam logic [2:0] CFG_MODE    = 3'd0;
	localparam logic [2:0] CFG_W_KEY   = 3'd1;
	localparam logic [2:0] CFG_W_NOISE = 3'd2;
	localparam logic [2:0] CFG_W_BW    = 3'd3;
	localparam logic [2:0] CFG_W_FAIR  = 3'd4;
	localparam logic [2:0] CFG_W_DL    = 3'd5;
	localparam logic [2:0] CFG_MEM_BW  = 3'd6;
	localparam logic [2:0] CFG_ENGINES = 3'd7;

	// Term order: key, noise, deadline, fairness, bandwidth.
	localparam int T_KEY   = 0;
	localparam int T_NOISE = 1;
	localparam int T_DL    = 2;
	localparam int T_FAIR  = 3;
	localparam int T_BW    = 4;

	typedef struct packed {
		logic             mode;
		logic [4:0][15:0] weight;
		logic [15:0]      mem_bw;
		logic [8:0]       engines;
	} cfg_t;

	typedef struct packed {
		logic        cand;
		logic        last;
		logic [7:0]  pos;
		logic [39:0] arrival;
		logic [23:0] key;
		logic [24:0] key_den;
		logic        has_dl;
		logic [14:0] dl_den;
		logic [15:0] noise_term;
		logic [8:0]  fair_den;
	} job_t;

endpackage

FILE: hw/rtl/wsjp_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on wsjp_pkg for widths.
module wsjp_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [wsjp_pkg::DIV_W-1:0]  num,
	input  logic [wsjp_pkg::DIV_W-1:0]  den,
	input  logic [wsjp_pkg::DIV_CW-1:0] nbits,
	output logic                        done,
	output logic [wsjp_pkg::DIV_W-1:0]  quo
);
	import wsjp_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [DIV_CW-1:0]   cnt_q;
	logic [DIV_W-1:0]    rem_q;
	logic [DIV_W-1:0]    num_q;
	logic [DIV_W-1:0]    den_q;
	logic [DIV_W-1:0]    quo_q;
	logic [DIV_W:0]      trial;
	logic                fits;
	logic [DIV_CW-1:0]   sh;

	assign trial = {rem_q, num_q[DIV_W-1]};
	assign fits  = trial >= {1'b0, den_q};
	assign sh    = DIV_CW'(DIV_W) - nbits;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= num << sh;
			den_q <= den;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? DIV_W'(trial - {1'b0, den_q}) : trial[DIV_W-1:0];
			num_q <= {num_q[DIV_W-2:0], 1'b0};
			quo_q <= {quo_q[DIV_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

FILE: hw/rtl/wsjp_front.sv
// Front end: classifies job records and precomputes cheap terms.
// Depends on wsjp_pkg for the job record.
module wsjp_front #(
	parameter int MAX_JOBS = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [39:0]         arrival_time,
	input  logic [39:0]         deadline,
	input  logic [39:0]         now,
	input  logic [23:0]         key_size,
	input  logic signed [17:0]  noise_margin,
	input  logic [7:0]          tenant,
	input  logic [15:0]         remaining_work,
	input  logic                last_job,
	output wsjp_pkg::job_t      job
);
	import wsjp_pkg::*;

	localparam int PW = $clog2(MAX_JOBS + 1);

	logic [PW-1:0] pos_q;
	logic          in_range;
	logic [39:0]   diff;
	logic [14:0]   slack;

	assign in_range = pos_q < PW'(MAX_JOBS);
	assign diff     = deadline - now;

	always_comb begin
		if (deadline <= now)
			slack = '0;
		else if (diff > 40'd20000)
			slack = 15'd20000;
		else
			slack = diff[14:0];
	end

	always_comb begin
		job.cand     = in_range && (remaining_work != '0) && (arrival_time <= now);
		job.last     = last_job;
		job.pos      = 8'(pos_q);
		job.arrival  = arrival_time;
		job.key      = key_size;
		job.key_den  = {1'b0, key_size} + 25'd256;
		job.has_dl   = deadline != '0;
		job.dl_den   = slack + 15'd500;
		job.fair_den = {1'b0, tenant} + 9'd5;
		if (noise_margin <= 18'sd0)
			job.noise_term = 16'hFFFF;
		else if (noise_margin >= 18'sd65536)
			job.noise_term = '0;
		else
			job.noise_term = 16'(17'd65536 - 17'(noise_margin));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (take) begin
			if (last_job)
				pos_q <= '0;
			else if (in_range)
				pos_q <= pos_q + 1'b1;
		end
	end

endmodule

FILE: hw/rtl/wsjp_queue.sv
// Short queue of classified job records between front and back.
// Depends on wsjp_pkg for the job record.
module wsjp_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  wsjp_pkg::job_t wr_job,
	input  logic           pop,
	output wsjp_pkg::job_t rd_job,
	output logic           full,
	output logic           empty
);
	import wsjp_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	job_t            mem_q [DEPTH];
	logic [AW-1:0]   wp_q;
	logic [AW-1:0]   rp_q;
	logic [AW:0]     cnt_q;

	assign full   = cnt_q == (AW+1)'(DEPTH);
	assign empty  = cnt_q == '0;
	assign rd_job = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (pop)
				rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

FILE: hw/rtl/wsjp_back.sv
// Back end: scores one job at a time, keeps the best and emits the pick.
// Depends on wsjp_pkg and wsjp_div.
module wsjp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  wsjp_pkg::cfg_t cfg,
	input  logic           q_empty,
	input  wsjp_pkg::job_t q_job,
	output logic           q_pop,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     job_index,
	output logic           found
);
	import wsjp_pkg::*;

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b00000000001,
		ST_DKEY  = 11'b00000000010,
		ST_DDL   = 11'b00000000100,
		ST_DFAIR = 11'b00000001000,
		ST_MULA  = 11'b00000010000,
		ST_MULB  = 11'b00000100000,
		ST_DT    = 11'b00001000000,
		ST_DBW   = 11'b00010000000,
		ST_PROD  = 11'b00100000000,
		ST_ACC   = 11'b01000000000,
		ST_DONE  = 11'b10000000000
	} state_t;

	state_t            state_q;
	job_t              job_q;
	logic              wait_q;
	logic [4:0][15:0]  term_q;
	logic [36:0]       mula_q;
	logic [DIV_W-1:0]  tnum_q;
	logic [DIV_W-1:0]  t_q;
	logic [31:0]       prod_q;
	logic [35:0]       acc_q;
	logic [2:0]        idx_q;
	logic [35:0]       lead_score_q;
	logic [39:0]       best_arr_q;
	logic [7:0]        best_pos_q;
	logic              any_q;
	logic              res_valid_q;
	logic [7:0]        res_idx_q;
	logic              res_found_q;

	logic              div_start;
	logic [DIV_W-1:0]  div_num;
	logic [DIV_W-1:0]  div_den;
	logic [DIV_CW-1:0] div_nb;
	logic              div_done;
	logic [DIV_W-1:0]  div_quo;
	logic [15:0]       quo_cap;
	logic [15:0]       bw_eff;
	logic              take_it;
	logic              can_emit;

	wsjp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.nbits  (div_nb),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign quo_cap  = (div_quo > DIV_W'(16'hFFFF)) ? 16'hFFFF : div_quo[15:0];
	assign bw_eff   = (cfg.mem_bw == '0) ? 16'd1 : cfg.mem_bw;
	assign can_emit = !res_valid_q || !out_stall;
	assign q_pop    = (state_q == ST_IDLE) && !q_empty;
	assign div_start = !wait_q && ((state_q == ST_DKEY) || (state_q == ST_DDL) ||
		(state_q == ST_DFAIR) || (state_q == ST_DT) || (state_q == ST_DBW));

	always_comb begin
		div_num = '0;
		div_den = '0;
		div_nb  = NB_KEY;
		unique case (state_q)
			ST_DKEY: begin
				div_num = DIV_W'(25'd16777216);
				div_den = DIV_W'(job_q.key_den);
			end
			ST_DDL: begin
				div_num = DIV_W'(25'd32768000);
				div_den = DIV_W'(job_q.dl_den);
				div_nb  = NB_DL;
			end
			ST_DFAIR: begin
				div_num = DIV_W'(19'd327680);
				div_den = DIV_W'(job_q.fair_den);
				div_nb  = NB_FAIR;
			end
			ST_DT: begin
				div_num = tnum_q;
				div_den = DIV_W'({bw_eff, 8'd0});
				div_nb  = NB_T;
			end
			ST_DBW: begin
				div_num = DIV_W'(17'd65536);
				div_den = t_q + 1'b1;
				div_nb  = NB_BW;
			end
			default: ;
		endcase
	end

	always_comb begin
		if (cfg.mode)
			take_it = !any_q || (acc_q > lead_score_q);
		else
			take_it = !any_q || (job_q.arrival < best_arr_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			wait_q       <= 1'b0;
			idx_q        <= '0;
			lead_score_q <= '0;
			best_arr_q   <= '0;
			best_pos_q   <= '0;
			any_q        <= 1'b0;
			res_valid_q  <= 1'b0;
		end else begin
			if (state_q == ST_DONE && job_q.last && can_emit)
				res_valid_q <= 1'b1;
			else if (!out_stall)
				res_valid_q <= 1'b0;
			if (div_start)
				wait_q <= 1'b1;
			unique case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						idx_q   <= '0;
						state_q <= q_job.cand ? ST_DKEY : ST_DONE;
					end
				end
				ST_DKEY: begin
					if (div_done) begin
						wait_q  <= 1'b0;
						state_q <= ST_DDL;
					end
				end
				ST_DDL: begin
					if (div_done) begin
						wait_q  <= 1'b0;
						state_q <= ST_DFAIR;
					end
				end
				ST_DFAIR: begin
					if (div_done) begin
						wait_q  <= 1'b0;
						state_q <= ST_MULA;
					end
				end
				ST_MULA: state_q <= ST_MULB;
				ST_MULB: state_q <= ST_DT;
				ST_DT: begin
					if (div_done) begin
						wait_q  <= 1'b0;
						state_q <= ST_DBW;
					end
				end
				ST_DBW: begin
					if (div_done) begin
						wait_q  <= 1'b0;
						state_q <= ST_PROD;
					end
				end
				ST_PROD: state_q <= ST_ACC;
				ST_ACC: begin
					if (idx_q == 3'd4) begin
						state_q <= ST_DONE;
					end else begin
						idx_q   <= idx_q + 1'b1;
						state_q <= ST_PROD;
					end
				end
				ST_DONE: begin
					if (!job_q.last) begin
						if (job_q.cand && take_it) begin
							lead_score_q <= acc_q;
							best_arr_q   <= job_q.arrival;
							best_pos_q   <= job_q.pos;
							any_q        <= 1'b1;
						end
						state_q <= ST_IDLE;
					end else if (can_emit) begin
						lead_score_q <= '0;
						best_arr_q   <= '0;
						best_pos_q   <= '0;
						any_q        <= 1'b0;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			job_q <= q_job;
			acc_q <= '0;
		end
		if (div_done) begin
			unique case (state_q)
				ST_DKEY:  term_q[T_KEY]  <= quo_cap;
				ST_DDL:   term_q[T_DL]   <= job_q.has_dl ? quo_cap : 16'd0;
				ST_DFAIR: term_q[T_FAIR] <= quo_cap;
				ST_DT:    t_q            <= (div_quo == '0) ? DIV_W'(1) : div_quo;
				ST_DBW:   term_q[T_BW]   <= quo_cap;
				default: ;
			endcase
		end
		if (state_q == ST_DKEY)
			term_q[T_NOISE] <= job_q.noise_term;
		if (state_q == ST_MULA)
			mula_q <= job_q.key * 13'd8000;
		if (state_q == ST_MULB)
			tnum_q <= DIV_W'(mula_q) * DIV_W'(cfg.engines);
		if (state_q == ST_PROD)
			prod_q <= cfg.weight[idx_q] * term_q[idx_q];
		if (state_q == ST_ACC)
			acc_q <= acc_q + 36'(prod_q);
		if (state_q == ST_DONE && job_q.last && can_emit) begin
			if (job_q.cand && take_it) begin
				res_idx_q   <= job_q.pos;
				res_found_q <= 1'b1;
			end else begin
				res_idx_q   <= any_q ? best_pos_q : 8'd0;
				res_found_q <= any_q;
			end
		end
	end

	assign out_valid = res_valid_q;
	assign job_index = res_idx_q;
	assign found     = res_found_q;

endmodule

FILE: hw/rtl/weighted_score_job_picker.sv
// Weighted score job picker: top level with configuration registers.
// A ready job holds the back end for five serial divisions in the shared
// one-bit-per-cycle divider and its multiply steps; a job that is not ready
// skips them. A closing record gives its result when done and out_stall allows.
// The back end takes one job at a time; a two-entry queue decouples input.
// Reset clears the list state and loads the default policy and weights.
module weighted_score_job_picker #(
	parameter int MAX_JOBS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [39:0]        arrival_time,
	input  logic [39:0]        deadline,
	input  logic [39:0]        now,
	input  logic [23:0]        key_size,
	input  logic signed [17:0] noise_margin,
	input  logic [7:0]         tenant,
	input  logic [15:0]        remaining_work,
	input  logic               last_job,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [7:0]         job_index,
	output logic               found,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_wdata
);
	import wsjp_pkg::*;

	cfg_t  cfg_q;
	job_t  f_job;
	job_t  q_job;
	logic  q_full;
	logic  q_empty;
	logic  q_pop;
	logic  take;

	assign in_stall = q_full;
	assign take     = in_valid && !q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.mode           <= 1'b1;
			cfg_q.weight[T_KEY]  <= 16'd12288;
			cfg_q.weight[T_NOISE] <= 16'd16384;
			cfg_q.weight[T_DL]   <= 16'd8192;
			cfg_q.weight[T_FAIR] <= 16'd6144;
			cfg_q.weight[T_BW]   <= 16'd8192;
			cfg_q.mem_bw         <= 16'd1024;
			cfg_q.engines        <= 9'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MODE:    cfg_q.mode           <= cfg_wdata[0];
				CFG_W_KEY:   cfg_q.weight[T_KEY]  <= cfg_wdata;
				CFG_W_NOISE: cfg_q.weight[T_NOISE] <= cfg_wdata;
				CFG_W_BW:    cfg_q.weight[T_BW]   <= cfg_wdata;
				CFG_W_FAIR:  cfg_q.weight[T_FAIR] <= cfg_wdata;
				CFG_W_DL:    cfg_q.weight[T_DL]   <= cfg_wdata;
				CFG_MEM_BW:  cfg_q.mem_bw         <= cfg_wdata;
				CFG_ENGINES: cfg_q.engines        <= cfg_wdata[8:0];
				default: ;
			endcase
		end
	end

	wsjp_front #(
		.MAX_JOBS (MAX_JOBS)
	) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.arrival_time   (arrival_time),
		.deadline       (deadline),
		.now            (now),
		.key_size       (key_size),
		.noise_margin   (noise_margin),
		.tenant         (tenant),
		.remaining_work (remaining_work),
		.last_job       (last_job),
		.job            (f_job)
	);

	wsjp_queue #(
		.DEPTH (2)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (take),
		.wr_job (f_job),
		.pop    (q_pop),
		.rd_job (q_job),
		.full   (q_full),
		.empty  (q_empty)
	);

	wsjp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.q_job     (q_job),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.job_index (job_index),
		.found     (found)
	);

endmodule
